// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ESV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define ESV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/esv_pkg.sv -----
// ----------------------------------------------------------------------------
// esv_pkg
// Shared widths, register indexes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package esv_pkg;

  localparam int SAMP_W   = 24;
  localparam int SET_W    = 9;
  localparam int ELEM_W   = 13;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 13;
  localparam int SUM_W    = 32;
  localparam int SQ_W     = 55;
  localparam int VAR_W    = 54;
  localparam int POS_W    = 12;
  localparam int FRAC_W   = 8;
  localparam int D_W      = 64;
  localparam int DVD_W    = D_W + FRAC_W;
  localparam int N2_W     = 17;
  localparam int DIV_STEPS = DVD_W;
  localparam int DCNT_W   = 7;

  localparam logic [CFG_IW-1:0] REG_SET_COUNT     = 2'd0;
  localparam logic [CFG_IW-1:0] REG_ELEMENT_COUNT = 2'd1;

  typedef struct packed {
    logic capture;
    logic first_set;
    logic last_elem;
    logic acc;
    logic mul;
    logic sub;
    logic div_step;
    logic load_out;
  } esv_cmd_t;

endpackage

// ----- rtl/esv_ram.sv -----
// ----------------------------------------------------------------------------
// esv_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module esv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/esv_ctrl.sv -----
// ----------------------------------------------------------------------------
// esv_ctrl
// Config registers, set/element counters and the per-sample sequencer.
// ----------------------------------------------------------------------------
module esv_ctrl #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int MAX_SETS     = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [esv_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [esv_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [((MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1)-1:0] pos,
  output logic [esv_pkg::SET_W-1:0]     sets,
  output esv_pkg::esv_cmd_t             cmd
);
  import esv_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  typedef enum logic [2:0] {IDLE, ACC, MUL, SUB, DIV, DONE} state_t;

  state_t               state;
  logic [SET_W-1:0]     set_count;
  logic [ELEM_W-1:0]    element_count;
  logic [SW-1:0]        set_index;
  logic [AW-1:0]        element_index;
  logic                 last_set;
  logic [DCNT_W-1:0]    div_cnt;

  logic [SET_W-1:0]     eff_sets;
  logic [16:0]          eff_elems;
  logic [SW-1:0]        last_s;
  logic [AW-1:0]        last_e;
  logic                 accept;
  logic                 is_last_s;
  logic                 is_last_e;
  logic                 out_free;

  always_comb begin
    if (set_count == '0) begin
      eff_sets = SET_W'(1);
    end else if (set_count > SET_W'(MAX_SETS)) begin
      eff_sets = SET_W'(MAX_SETS);
    end else begin
      eff_sets = set_count;
    end
    if (element_count == '0) begin
      eff_elems = 17'd1;
    end else if ({4'b0, element_count} > 17'(MAX_ELEMENTS)) begin
      eff_elems = 17'(MAX_ELEMENTS);
    end else begin
      eff_elems = {4'b0, element_count};
    end
  end

  assign last_s    = SW'(eff_sets - SET_W'(1));
  assign last_e    = AW'(eff_elems - 17'd1);
  assign is_last_s = (set_index == last_s);
  assign is_last_e = (element_index == last_e);

  assign sample_ready = (state == IDLE);
  assign accept       = sample_valid && sample_ready;
  assign out_free     = !result_valid || result_ready;
  assign pos          = element_index;
  assign sets         = eff_sets;

  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.first_set = (set_index == '0);
    cmd.last_elem = is_last_e;
    cmd.acc       = (state == ACC);
    cmd.mul       = (state == MUL);
    cmd.sub       = (state == SUB);
    cmd.div_step  = (state == DIV);
    cmd.load_out  = (state == DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      set_count     <= SET_W'(1);
      element_count <= ELEM_W'(1);
      set_index     <= '0;
      element_index <= '0;
      last_set      <= 1'b0;
      div_cnt       <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cfg_we && (cfg_index == REG_SET_COUNT || cfg_index == REG_ELEMENT_COUNT)) begin
            if (cfg_index == REG_SET_COUNT) begin
              set_count <= cfg_data[SET_W-1:0];
            end else begin
              element_count <= cfg_data;
            end
            set_index     <= '0;
            element_index <= '0;
          end else if (accept) begin
            last_set <= is_last_s;
            if (is_last_e) begin
              element_index <= '0;
              set_index     <= is_last_s ? '0 : set_index + SW'(1);
            end else begin
              element_index <= element_index + AW'(1);
            end
            state <= ACC;
          end
        end
        ACC: begin
          state <= last_set ? MUL : IDLE;
        end
        MUL: begin
          state <= SUB;
        end
        SUB: begin
          div_cnt <= '0;
          state   <= DIV;
        end
        DIV: begin
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/esv_dpath.sv -----
// ----------------------------------------------------------------------------
// esv_dpath
// Accumulator stores, moment arithmetic and a bit-serial divider.
// ----------------------------------------------------------------------------
module esv_dpath #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                          clk,
  input  logic [esv_pkg::SAMP_W-1:0]    sample,
  input  logic [((MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1)-1:0] pos,
  input  logic [esv_pkg::SET_W-1:0]     sets,
  input  esv_pkg::esv_cmd_t             cmd,
  output logic [esv_pkg::VAR_W-1:0]     variance_q8,
  output logic [esv_pkg::POS_W-1:0]     position,
  output logic                          block_end
);
  import esv_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic signed [SAMPLE_BITS-1:0] xs;
  logic signed [SAMP_W-1:0]      x_ext;
  logic signed [SAMP_W-1:0]      x_r;
  logic [2*SAMP_W-1:0]           x2_r;
  logic                          first_r;
  logic                          end_r;
  logic [AW-1:0]                 pos_r;
  logic [SUM_W-1:0]              rd_sum;
  logic [SQ_W-1:0]               rd_sq;
  logic signed [SUM_W-1:0]       new_sum;
  logic [SQ_W-1:0]               new_sq;
  logic signed [SUM_W-1:0]       sum_r;
  logic [SQ_W-1:0]               sq_r;
  logic [SUM_W-1:0]              mag;
  logic [D_W-1:0]                s2_r;
  logic [D_W-1:0]                nsq_r;
  logic [N2_W-1:0]               n2_r;
  logic [DVD_W-1:0]              dvd;
  logic [N2_W-1:0]               rem;
  logic [VAR_W-1:0]              quo;
  logic [N2_W:0]                 trial;
  logic                          ge;
  logic [POS_W+AW-1:0]           pos_ext;

  assign xs    = sample[SAMPLE_BITS-1:0];
  assign x_ext = SAMP_W'(xs);

  esv_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ELEMENTS)) u_sum_ram (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (pos_r),
    .wdata (new_sum),
    .re    (cmd.capture),
    .raddr (pos),
    .rdata (rd_sum)
  );

  esv_ram #(.WIDTH(SQ_W), .DEPTH(MAX_ELEMENTS)) u_sq_ram (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (pos_r),
    .wdata (new_sq),
    .re    (cmd.capture),
    .raddr (pos),
    .rdata (rd_sq)
  );

  // Set 0 overwrites whatever the store holds.
  assign new_sum = first_r ? SUM_W'(x_r) : $signed(rd_sum) + SUM_W'(x_r);
  assign new_sq  = first_r ? SQ_W'(x2_r) : rd_sq + SQ_W'(x2_r);
  assign mag     = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  // Restoring division of (d << 8) by N^2, one quotient bit per cycle.
  assign trial = {rem, dvd[DVD_W-1]};
  assign ge    = trial >= {1'b0, n2_r};

  assign pos_ext = {{POS_W{1'b0}}, pos_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r     <= x_ext;
      // square formed at full product width
      x2_r    <= $unsigned((2*SAMP_W)'(x_ext) * (2*SAMP_W)'(x_ext));
      first_r <= cmd.first_set;
      end_r   <= cmd.last_elem;
      pos_r   <= pos;
    end
    if (cmd.acc) begin
      sum_r <= new_sum;
      sq_r  <= new_sq;
    end
    if (cmd.mul) begin
      s2_r  <= D_W'(mag) * D_W'(mag);
      nsq_r <= D_W'(sets) * D_W'(sq_r);
      n2_r  <= N2_W'(sets * sets);
    end
    if (cmd.sub) begin
      dvd <= {((s2_r > nsq_r) ? '0 : nsq_r - s2_r), {FRAC_W{1'b0}}};
      rem <= '0;
      quo <= '0;
    end
    if (cmd.div_step) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= ge ? N2_W'(trial - {1'b0, n2_r}) : N2_W'(trial);
      quo <= {quo[VAR_W-2:0], ge};
    end
    if (cmd.load_out) begin
      variance_q8 <= quo;
      position    <= pos_ext[POS_W-1:0];
      block_end   <= end_r;
    end
  end

endmodule

// ----- rtl/elementwise_set_variance_top.sv -----
// ----------------------------------------------------------------------------
// elementwise_set_variance_top
// Per-position population variance over set_count sets of element_count
// samples. A sample outside the last set of a block is captured, then a
// read-modify-write updates the sum and sum-of-squares stores. A sample in
// the last set takes these steps, then a multiply step, a subtract step,
// the bit-serial divider that forms (N*sumsq-sum^2)*256 / N^2, and a load
// of the output register, which waits while the previous result is unread.
// One sample is in flight at a time; a finished result waits in the output
// register while the next sample is taken. The stores need no clearing
// after reset since the first set of each block writes every position.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elementwise_set_variance_top #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int MAX_SETS     = 256,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [esv_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [esv_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic [esv_pkg::SAMP_W-1:0]    sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [esv_pkg::VAR_W-1:0]     variance_q8,
  output logic [esv_pkg::POS_W-1:0]     position,
  output logic                          block_end
);
  import esv_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic [AW-1:0]    pos;
  logic [SET_W-1:0] sets;
  esv_cmd_t         cmd;

  esv_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS), .MAX_SETS(MAX_SETS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pos          (pos),
    .sets         (sets),
    .cmd          (cmd)
  );

  esv_dpath #(.MAX_ELEMENTS(MAX_ELEMENTS), .SAMPLE_BITS(SAMPLE_BITS)) u_dpath (
    .clk         (clk),
    .sample      (sample),
    .pos         (pos),
    .sets        (sets),
    .cmd         (cmd),
    .variance_q8 (variance_q8),
    .position    (position),
    .block_end   (block_end)
  );

  // one sample at a time
  `ESV_ASSERT_NEXT(a_single_item, clk, rst, sample_valid && sample_ready, !sample_ready, "second beat taken while busy")
  // a result only appears after the sequencer was busy
  `ESV_ASSERT_NOW(a_result_from_work, clk, rst, $rose(result_valid), $past(!sample_ready), "result without a running sample")
  // the output register is loaded only from the busy side
  `ESV_ASSERT_NEXT(a_no_result_idle, clk, rst, !result_valid && sample_ready && !sample_valid, !result_valid, "result appeared while idle")

endmodule
